// ===== design/sbbs_pkg.sv =====
// Shared types and constants for the sorted bad-block set.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package sbbs_pkg;

    localparam int CAPACITY    = 256;
    localparam int BLOCK_BITS  = 48;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W   = 9;
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int IN_DATA_W   = ((BLOCK_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((4 * OUT_CNT_W + 7) / 8) * 8;

    localparam logic [OUT_CNT_W-1:0] SAT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_CORRUPT = 2'd2
    } err_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE
    } state_t;

    // Control from the sequencer to the chain of cells.
    typedef struct packed {
        logic capture;   // compare the incoming block against every cell
        logic insert;    // shift the larger entries up and write the new block
    } sbbs_ctrl_t;

endpackage

// ===== design/sorted_bad_block_set_core.sv =====
// Top level of the sorted bad-block set: handshakes, sequencer, counters.
// Uses sbbs_pkg and sbbs_chain.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one bad-block report per transfer: the block number
// in s_tdata and the error kind in s_tuser. For each report exactly one result
// leaves on the master channel: the new and full flags in m_tuser and the
// entry count and the three per-kind counters in m_tdata.
// A report is compared against every cell of the chain in the cycle it is
// accepted; in the cycle after that the match flags are reduced, and once the
// output register is free the chain shifts and the result is loaded into it.
// A new report is taken only after the previous one has gone through the
// compare, reduce and shift steps of the cell chain.
// A finished result waits in the output register while the next report is
// already accepted and compared; if the receiver still stalls when that
// report is ready to commit, the sequencer holds until the output is free.
// Reset empties the store and clears all counters at once; the cell contents
// themselves are not cleared, as only occupied cells are ever looked at.

module sorted_bad_block_set_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbbs_pkg::IN_DATA_W-1:0] s_tdata,   // block_number
    input  logic [1:0]                     s_tuser,   // error_kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // entries_held, read_errors, write_errors, corruption_errors
    output logic [sbbs_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser    // is_new, store_full
);
    import sbbs_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    sbbs_ctrl_t             ctrl;
    logic                   found;
    logic                   full;
    logic                   commit;

    logic [BLOCK_BITS-1:0]  block_reg;
    logic [1:0]             kind_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [OUT_CNT_W-1:0]   rd_cnt_reg;
    logic [OUT_CNT_W-1:0]   rd_cnt_next;
    logic [OUT_CNT_W-1:0]   wr_cnt_reg;
    logic [OUT_CNT_W-1:0]   wr_cnt_next;
    logic [OUT_CNT_W-1:0]   cr_cnt_reg;
    logic [OUT_CNT_W-1:0]   cr_cnt_next;

    logic                   out_valid_reg;
    logic [1:0]             out_user_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.insert  = 1'b0;
        commit       = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                ctrl.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    commit      = 1'b1;
                    ctrl.insert = !found && !full;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            block_reg <= s_tdata[BLOCK_BITS-1:0];
            kind_reg  <= s_tuser;
        end
    end

    sbbs_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (count_reg),
        .key       (s_tdata[BLOCK_BITS-1:0]),
        .new_block (block_reg),
        .found     (found)
    );

    // The per-kind error counters saturate at their all-ones value.
    always_comb
    begin
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        wr_cnt_next = wr_cnt_reg;
        cr_cnt_next = cr_cnt_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            case (kind_reg)
                KIND_READ:
                begin
                    if (rd_cnt_reg != SAT_MAX)
                    begin
                        rd_cnt_next = rd_cnt_reg + OUT_CNT_W'(1);
                    end
                end
                KIND_WRITE:
                begin
                    if (wr_cnt_reg != SAT_MAX)
                    begin
                        wr_cnt_next = wr_cnt_reg + OUT_CNT_W'(1);
                    end
                end
                KIND_CORRUPT:
                begin
                    if (cr_cnt_reg != SAT_MAX)
                    begin
                        cr_cnt_next = cr_cnt_reg + OUT_CNT_W'(1);
                    end
                end
                default:
                begin
                    rd_cnt_next = rd_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            wr_cnt_reg <= '0;
            cr_cnt_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            wr_cnt_reg <= wr_cnt_next;
            cr_cnt_reg <= cr_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_user_reg <= {!found && full, !found && !full};
            out_data_reg <= OUT_DATA_W'({cr_cnt_next, wr_cnt_next, rd_cnt_next,
                                         OUT_CNT_W'(count_next)});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/sbbs_cell.sv =====
// One storage cell of the sorted chain: holds an entry, compares it with the
// incoming block and takes its lower neighbour's entry on insertion. Uses sbbs_pkg.
`timescale 1ns / 1ps

module sbbs_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbbs_pkg::sbbs_ctrl_t              ctrl,
    input  logic                              occupied,
    input  logic [sbbs_pkg::BLOCK_BITS-1:0]   key,
    input  logic [sbbs_pkg::BLOCK_BITS-1:0]   new_block,
    input  logic                              prev_ge,
    input  logic [sbbs_pkg::BLOCK_BITS-1:0]   prev_entry,
    output logic [sbbs_pkg::BLOCK_BITS-1:0]   entry,
    output logic                              ge,
    output logic                              eq
);
    import sbbs_pkg::*;

    logic [BLOCK_BITS-1:0] entry_reg;
    logic [BLOCK_BITS-1:0] entry_next;
    logic                  ge_reg;
    logic                  eq_reg;

    // An empty cell counts as larger than any block, so the first cell with
    // its flag set is the insertion point.
    always_comb
    begin
        entry_next = entry_reg;
        if (ge_reg && !prev_ge)
        begin
            entry_next = new_block;
        end
        else if (prev_ge)
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            ge_reg <= !occupied || (entry_reg >= key);
            eq_reg <= occupied && (entry_reg == key);
        end
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

// ===== design/sbbs_chain.sv =====
// Row of sorted storage cells with a registered OR tree over the match flags.
// Uses sbbs_pkg and sbbs_cell.
`timescale 1ns / 1ps

module sbbs_chain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbbs_pkg::sbbs_ctrl_t              ctrl,
    input  logic [sbbs_pkg::CNT_W-1:0]        count,
    input  logic [sbbs_pkg::BLOCK_BITS-1:0]   key,
    input  logic [sbbs_pkg::BLOCK_BITS-1:0]   new_block,
    output logic                              found
);
    import sbbs_pkg::*;

    logic [BLOCK_BITS-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]   ge_flags;
    logic [CAPACITY-1:0]   eq_flags;
    logic [NUM_GROUPS-1:0] group_reg;
    logic [NUM_GROUPS-1:0] group_next;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  prev_ge;
        logic [BLOCK_BITS-1:0] prev_entry;
        logic                  occupied;

        if (i == 0)
        begin : g_first
            assign prev_ge    = 1'b0;
            assign prev_entry = '0;
        end
        else
        begin : g_rest
            assign prev_ge    = ge_flags[i-1];
            assign prev_entry = entries[i-1];
        end

        assign occupied = CNT_W'(i) < count;

        sbbs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .key        (key),
            .new_block  (new_block),
            .prev_ge    (prev_ge),
            .prev_entry (prev_entry),
            .entry      (entries[i]),
            .ge         (ge_flags[i]),
            .eq         (eq_flags[i])
        );
    end

    // First level of the match tree: one OR per group of cells.
    always_comb
    begin
        group_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | eq_flags[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
        end
        else
        begin
            group_reg <= group_next;
        end
    end

    assign found = |group_reg;

endmodule

// ===== tb/sbbs_checker.sv =====
// Checker for the sorted bad-block set: watches both stream channels, predicts each result
// and compares it with what the block returns. Depends on sbbs_pkg only.
`timescale 1ns / 1ps

module sbbs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sbbs_pkg::IN_DATA_W-1:0]  s_tdata,   // block_number
    input  logic [1:0]                      s_tuser,   // error_kind
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // entries_held, read_errors, write_errors, corruption_errors
    input  logic [sbbs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]                      m_tuser,   // is_new, store_full
    output int                              mismatch_count,
    output int                              pending,
    output int                              inserted,
    output int                              repeats,
    output int                              dropped
);

    import sbbs_pkg::*;

    typedef struct packed {
        logic                 is_new;
        logic                 store_full;
        logic [OUT_CNT_W-1:0] entries_held;
        logic [OUT_CNT_W-1:0] read_errors;
        logic [OUT_CNT_W-1:0] write_errors;
        logic [OUT_CNT_W-1:0] corruption_errors;
    } outcome_t;

    // Predicted contents of the store, ascending; only the first held entries mean anything.
    logic [BLOCK_BITS-1:0] bad_blocks [CAPACITY];
    int                    held;
    logic [OUT_CNT_W-1:0]  read_cnt;
    logic [OUT_CNT_W-1:0]  write_cnt;
    logic [OUT_CNT_W-1:0]  corrupt_cnt;
    outcome_t              awaited [$];

    function automatic outcome_t record_report(logic [BLOCK_BITS-1:0] blk, logic [1:0] kind);
        int       slot;
        bit       present;
        outcome_t res;
        slot    = held;
        present = 1'b0;
        for (int i = 0; i < held; i++)
        begin
            if (bad_blocks[i] >= blk)
            begin
                slot    = i;
                present = (bad_blocks[i] == blk);
                break;
            end
        end
        res.is_new     = 1'b0;
        res.store_full = 1'b0;
        if (present)
            repeats++;
        else if (held >= CAPACITY)
        begin
            res.store_full = 1'b1;
            dropped++;
        end
        else
        begin
            for (int i = held; i > slot; i--)
                bad_blocks[i] = bad_blocks[i - 1];
            bad_blocks[slot] = blk;
            held++;
            res.is_new = 1'b1;
            inserted++;
            // The unused kind is stored but counted nowhere; counters stop at their maximum.
            case (kind)
                KIND_READ:    if (read_cnt != SAT_MAX) read_cnt++;
                KIND_WRITE:   if (write_cnt != SAT_MAX) write_cnt++;
                KIND_CORRUPT: if (corrupt_cnt != SAT_MAX) corrupt_cnt++;
                default:      ;
            endcase
        end
        res.entries_held      = held[OUT_CNT_W-1:0];
        res.read_errors       = read_cnt;
        res.write_errors      = write_cnt;
        res.corruption_errors = corrupt_cnt;
        return res;
    endfunction

    task automatic note_failure(string text);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, text);
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want !== got)
            note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            awaited.delete();
            held           = 0;
            read_cnt       = '0;
            write_cnt      = '0;
            corrupt_cnt    = '0;
            mismatch_count = 0;
            pending        = 0;
            inserted       = 0;
            repeats        = 0;
            dropped        = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited.push_back(record_report(s_tdata[BLOCK_BITS-1:0], s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (awaited.size() == 0)
                    note_failure($sformatf("result with nothing outstanding, tdata %h tuser %b",
                                           m_tdata, m_tuser));
                else
                begin
                    want = awaited.pop_front();
                    compare_field("is_new", want.is_new, m_tuser[0]);
                    compare_field("store_full", want.store_full, m_tuser[1]);
                    compare_field("entries_held", want.entries_held, m_tdata[8:0]);
                    compare_field("read_errors", want.read_errors, m_tdata[17:9]);
                    compare_field("write_errors", want.write_errors, m_tdata[26:18]);
                    compare_field("corruption_errors", want.corruption_errors,
                                  m_tdata[35:27]);
                    compare_field("tdata padding", 0, m_tdata[OUT_DATA_W-1:4*OUT_CNT_W]);
                end
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== tb/sorted_bad_block_set_core_tb.sv =====
// Top of the sorted bad-block set testbench: clock, reset, report stimulus and verdict.
// Depends on sbbs_pkg, sorted_bad_block_set_core and sbbs_checker.
`timescale 1ns / 1ps

module sorted_bad_block_set_core_tb;

    import sbbs_pkg::*;

    localparam int              REPORTS     = 800;
    localparam int              CYCLE_LIMIT = 400000;
    localparam logic [1:0]      KIND_UNUSED = 2'd3;
    localparam logic [47:0]     TOP_BLOCK   = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    int mismatch_count;
    int pending;
    int inserted;
    int repeats;
    int dropped;

    int                    sent;
    int                    cycles;
    int                    quiet_run;
    logic [BLOCK_BITS-1:0] known_blocks [$];

    sorted_bad_block_set_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sbbs_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .inserted       (inserted),
        .repeats        (repeats),
        .dropped        (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_known(logic [BLOCK_BITS-1:0] blk);
        foreach (known_blocks[i])
            if (known_blocks[i] == blk)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] fresh_block();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        while (is_known(wide[BLOCK_BITS-1:0]))
            wide = {$urandom(), $urandom()};
        return wide[BLOCK_BITS-1:0];
    endfunction

    // Offers one report, idling first for a random gap, and returns at the transfer.
    task automatic send_report(input logic [BLOCK_BITS-1:0] blk, input logic [1:0] kind);
        int gap;
        int r;
        if (quiet_run > 0)
        begin
            quiet_run--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                quiet_run = $urandom_range(20, 60);
            if (r < 45)
                gap = 0;
            else if (r < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        if (!is_known(blk))
            known_blocks.push_back(blk);
        sent++;
    endtask

    task automatic send_random_report();
        logic [BLOCK_BITS-1:0] blk;
        logic [1:0]            kind;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 30 && known_blocks.size() > 0)
            blk = known_blocks[$urandom_range(0, known_blocks.size() - 1)];
        else if (r < 50 && known_blocks.size() > 0)
            // Close neighbours of held entries exercise the ordering at its finest.
            blk = known_blocks[$urandom_range(0, known_blocks.size() - 1)]
                  + BLOCK_BITS'($urandom_range(0, 6)) - BLOCK_BITS'(3);
        else if (r < 70)
            blk = BLOCK_BITS'($urandom_range(0, 1023));
        else
            blk = fresh_block();
        kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        send_report(blk, kind);
    endtask

    // Receiver: random stalls, with two long hold-offs that back the block up.
    initial
    begin : receiver
        int r;
        int holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 99);
            if ((holds_done == 0 && sent >= 40) || (holds_done == 1 && sent >= 500))
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                holds_done++;
            end
            else if (r < 50)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (r < 55)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(40, 100)) @(posedge clk);
            end
            else if (r < 92)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
        $display("sorted_bad_block_set_core_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        sent      = 0;
        quiet_run = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, every kind, repeats and inserts at the front, middle and end.
        send_report(48'd0, KIND_READ);
        send_report(TOP_BLOCK, KIND_WRITE);
        send_report(48'd0, KIND_CORRUPT);
        send_report(TOP_BLOCK, KIND_READ);
        send_report(48'd1, KIND_UNUSED);
        send_report(TOP_BLOCK - 48'd1, KIND_CORRUPT);
        send_report(48'h5555_5555_5555, KIND_READ);
        send_report(48'hAAAA_AAAA_AAAA, KIND_WRITE);
        send_report(48'h8000_0000_0000, KIND_CORRUPT);
        send_report(48'd1, KIND_WRITE);
        send_report(48'h7FFF_FFFF_FFFF, KIND_UNUSED);
        send_report(48'd60, KIND_READ);
        send_report(48'd50, KIND_WRITE);
        send_report(48'd40, KIND_CORRUPT);
        send_report(48'd45, KIND_READ);
        send_report(48'd2, KIND_WRITE);
        send_report(48'h1000, KIND_READ);
        send_report(48'h1000, KIND_WRITE);
        send_report(48'h8000_0000_0000, KIND_UNUSED);

        // Random reports, carried on until the store has certainly overflowed.
        while (sent < REPORTS || known_blocks.size() <= CAPACITY + 10)
            send_random_report();

        // With the store full, repeats are still recognised and fresh blocks are dropped.
        send_report(48'd0, KIND_READ);
        send_report(TOP_BLOCK, KIND_CORRUPT);
        send_report(fresh_block(), KIND_WRITE);
        s_tvalid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        @(negedge clk);

        $display("%0d reports sent: %0d inserted, %0d repeats, %0d dropped with the store full",
                 sent, inserted, repeats, dropped);
        $display("receiver held off twice for 300 cycles; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("sorted_bad_block_set_core_tb: clean");
        else
            $display("sorted_bad_block_set_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sbbs_pkg.sv
design/sbbs_cell.sv
design/sbbs_chain.sv
design/sorted_bad_block_set_core.sv
tb/sbbs_checker.sv
tb/sorted_bad_block_set_core_tb.sv
